[rtl/core/decimal_text_to_fixed_point_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to fixed-point converter
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DTFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dtfp_pkg.sv]
// ----------------------------------------------------------------------------
// dtfp_pkg
// Types, constants and helpers shared by the text to fixed-point converter.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    localparam int FRAC_BITS_DEF = 16;   // fraction bits of the result
    localparam int FRAC_DIGITS   = 9;    // decimal fraction digits kept
    localparam int INT_BITS      = 31;   // integer part saturates at 2^INT_BITS - 1

    localparam int INT_ACC_W  = 31;
    localparam int FRAC_ACC_W = 30;
    localparam int CNT_W      = 4;
    localparam int VAL_W      = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [INT_ACC_W-1:0] INT_MAX = INT_ACC_W'((64'd1 << INT_BITS) - 64'd1);
    localparam logic [VAL_W-1:0]     MAG_MAX = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SUM,
        BK_OUT
    } t_back_state;

    // One parsed string, handed from the front to the back end.
    typedef struct packed {
        logic                  negative;
        logic                  invalid;
        logic                  overflow;
        logic [INT_ACC_W-1:0]  int_acc;
        logic [FRAC_ACC_W-1:0] frac_acc;
        logic [CNT_W-1:0]      frac_cnt;
    } t_rec;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
        case (n)
            4'd0:    return 30'd1;
            4'd1:    return 30'd10;
            4'd2:    return 30'd100;
            4'd3:    return 30'd1000;
            4'd4:    return 30'd10000;
            4'd5:    return 30'd100000;
            4'd6:    return 30'd1000000;
            4'd7:    return 30'd10000000;
            4'd8:    return 30'd100000000;
            default: return 30'd1000000000;
        endcase
    endfunction

endpackage

[rtl/core/dtfp_in_if.sv]
// ----------------------------------------------------------------------------
// dtfp_in_if
// Character channel: one ASCII character and its end-of-string flag.
// ----------------------------------------------------------------------------
interface dtfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source(output valid, output character, output last_char, input ready);
    modport sink(input valid, input character, input last_char, output ready);
endinterface

[rtl/core/dtfp_out_if.sv]
// ----------------------------------------------------------------------------
// dtfp_out_if
// Result channel: signed fixed-point value and status.
// ----------------------------------------------------------------------------
interface dtfp_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] fixed_value;
    logic [1:0]         status;

    modport source(output valid, output fixed_value, output status, input ready);
    modport sink(input valid, input fixed_value, input status, output ready);
endinterface

[rtl/core/decimal_text_to_fixed_point.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses ASCII decimal strings into signed fixed-point values.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one ASCII character per item with last_char marking the end
//   of a string: optional leading '-', integer digits, optional '.', fraction
//   digits. o_out carries one item per string: fixed_value (48-bit two's
//   complement, FRAC_BITS fraction bits) and status (0 ok, 1 invalid
//   character, 2 saturated). An invalid string always yields value 0.
//   Characters are taken one per cycle while the queue is not full; a
//   finished string is queued (two deep) for the back end, which divides
//   the fraction digits by 10^n one quotient bit per cycle. The back end
//   works on one string at a time, so short strings are limited by the
//   divider. With an idle back end a string's record passes the queue, the
//   division steps, the sum register and then the result register.
//   When the receiver stalls, the result register holds, the back end and
//   then the queue fill, and i_in.ready drops only when the queue is full.
//   Reset (synchronous, active low) clears the parser, the queue and the
//   result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "decimal_text_to_fixed_point_defines.svh"

module decimal_text_to_fixed_point #(
    parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtfp_in_if.sink    i_in,
    dtfp_out_if.source o_out
);
    import dtfp_pkg::*;

    // parser -> queue
    logic       push;
    t_rec       front_rec;
    // queue -> back end
    logic       pop;
    t_rec       queue_rec;
    logic       q_full;
    logic       q_empty;
    t_back_stat back_stat;

    // Front: classify characters and accumulate digits; push on last char.
    dtfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    // Queue: lets the parser run ahead while the back end divides.
    dtfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: scale the fraction, apply sign and clamp, hold the result.
    dtfp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (queue_rec),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_stat  (back_stat),
        .o_out   (o_out)
    );

    // Invalid strings never carry a value.
    `DTFP_ASSERT_NOW(a_invalid_zero, o_out.valid && (o_out.status == ST_INVALID), o_out.fixed_value == '0, "invalid result with nonzero value")

    // A full queue must stall the character channel.
    `DTFP_ASSERT_NOW(a_full_stalls, q_full, !i_in.ready, "character taken while queue full")

    // An idle back end picks up a waiting record at once.
    `DTFP_ASSERT_NEXT(a_back_starts, !back_stat.busy && !q_empty, back_stat.busy, "back end idle with queued record")

endmodule

[rtl/core/dtfp_front.sv]
// ----------------------------------------------------------------------------
// dtfp_front
// Character parser: classifies each character and accumulates the digits.
// ----------------------------------------------------------------------------
module dtfp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtfp_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output dtfp_pkg::t_rec o_rec
);
    import dtfp_pkg::*;

    logic                   r_at_start, n_at_start;
    logic                   r_neg, n_neg;
    logic                   r_in_frac, n_in_frac;
    logic [INT_ACC_W-1:0]   r_int, n_int;
    logic [FRAC_ACC_W-1:0]  r_frac, n_frac;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_inv, n_inv;
    logic                   r_ovf, n_ovf;

    logic                   take;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [INT_ACC_W+3:0]   int_sum;
    logic [FRAC_ACC_W+3:0]  frac_sum;

    assign i_in.ready = !i_full;
    assign take       = i_in.valid && i_in.ready;
    assign is_digit   = (i_in.character >= CH_ZERO) && (i_in.character <= CH_NINE);
    assign digit      = 4'(i_in.character - CH_ZERO);

    // times ten as shift-and-add
    assign int_sum  = (INT_ACC_W+4)'({r_int, 3'b000}) + (INT_ACC_W+4)'({r_int, 1'b0})
                    + (INT_ACC_W+4)'(digit);
    assign frac_sum = (FRAC_ACC_W+4)'({r_frac, 3'b000}) + (FRAC_ACC_W+4)'({r_frac, 1'b0})
                    + (FRAC_ACC_W+4)'(digit);

    always_comb begin
        n_at_start = 1'b0;
        n_neg      = r_neg;
        n_in_frac  = r_in_frac;
        n_int      = r_int;
        n_frac     = r_frac;
        n_cnt      = r_cnt;
        n_inv      = r_inv;
        n_ovf      = r_ovf;
        if (is_digit) begin
            if (r_in_frac) begin
                // drop digits past the kept precision
                if (r_cnt < CNT_W'(FRAC_DIGITS)) begin
                    n_frac = FRAC_ACC_W'(frac_sum);
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end else if (int_sum > (INT_ACC_W+4)'(INT_MAX)) begin
                n_int = INT_MAX;
                n_ovf = 1'b1;
            end else begin
                n_int = INT_ACC_W'(int_sum);
            end
        end else if (i_in.character == CH_MINUS) begin
            if (r_at_start) begin
                n_neg = 1'b1;
            end else begin
                n_inv = 1'b1;
            end
        end else if (i_in.character == CH_DOT) begin
            if (r_in_frac) begin
                n_inv = 1'b1;
            end else begin
                n_in_frac = 1'b1;
            end
        end else begin
            n_inv = 1'b1;
        end
    end

    assign o_push         = take && i_in.last_char;
    assign o_rec.negative = n_neg;
    assign o_rec.invalid  = n_inv;
    assign o_rec.overflow = n_ovf;
    assign o_rec.int_acc  = n_int;
    assign o_rec.frac_acc = n_frac;
    assign o_rec.frac_cnt = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_at_start <= 1'b1;
            r_neg      <= 1'b0;
            r_in_frac  <= 1'b0;
            r_int      <= '0;
            r_frac     <= '0;
            r_cnt      <= '0;
            r_inv      <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (take) begin
            r_at_start <= n_at_start;
            r_neg      <= n_neg;
            r_in_frac  <= n_in_frac;
            r_int      <= n_int;
            r_frac     <= n_frac;
            r_cnt      <= n_cnt;
            r_inv      <= n_inv;
            r_ovf      <= n_ovf;
        end
    end

endmodule

[rtl/core/dtfp_queue.sv]
// ----------------------------------------------------------------------------
// dtfp_queue
// Short record queue between the parser and the scaling back end.
// ----------------------------------------------------------------------------
module dtfp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dtfp_pkg::t_rec i_rec,
    input  logic           i_pop,
    output dtfp_pkg::t_rec o_rec,
    output logic           o_full,
    output logic           o_empty
);
    import dtfp_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/dtfp_back.sv]
// ----------------------------------------------------------------------------
// dtfp_back
// Scaling back end: fraction division by 10^n, sum, clamp, sign, result register.
// ----------------------------------------------------------------------------
module dtfp_back #(
    parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtfp_pkg::t_rec       i_rec,
    input  logic                 i_empty,
    output logic                 o_pop,
    output dtfp_pkg::t_back_stat o_stat,
    dtfp_out_if.source           o_out
);
    import dtfp_pkg::*;

    localparam int STEP_W = $clog2(FRAC_BITS);
    localparam int MAG_W  = INT_ACC_W + FRAC_BITS;

    t_back_state            r_state, n_state;
    t_rec                   r_rec;
    logic [FRAC_ACC_W-1:0]  r_rem;
    logic [FRAC_ACC_W-1:0]  r_div;
    logic [FRAC_BITS-1:0]   r_quo;
    logic [STEP_W-1:0]      r_step;
    logic [MAG_W-1:0]       r_mag;

    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_value;
    t_status                r_status;

    logic                   load_out;
    logic [FRAC_ACC_W:0]    trial;
    logic                   q_bit;
    logic [63:0]            mag_ext;
    logic                   too_wide;
    logic [VAL_W-1:0]       mag_clamped;
    logic [VAL_W-1:0]       value_next;
    t_status                status_next;

    // restoring division step: remainder stays below the divisor
    assign trial = {r_rem, 1'b0};
    assign q_bit = (trial >= {1'b0, r_div});

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec  <= i_rec;
            r_rem  <= i_rec.frac_acc;
            r_div  <= pow10(i_rec.frac_cnt);
            r_quo  <= '0;
            r_step <= '0;
        end else if (r_state == BK_DIV) begin
            r_rem  <= q_bit ? FRAC_ACC_W'(trial - {1'b0, r_div}) : FRAC_ACC_W'(trial);
            r_quo  <= {r_quo[FRAC_BITS-2:0], q_bit};
            r_step <= r_step + STEP_W'(1);
        end
        if (r_state == BK_SUM) begin
            r_mag <= {r_rec.int_acc, FRAC_BITS'(0)} + MAG_W'(r_quo);
        end
    end

    // clamp to the 48-bit range, then negate toward zero
    assign mag_ext     = 64'(r_mag);
    assign too_wide    = (mag_ext > 64'(MAG_MAX));
    assign mag_clamped = too_wide ? MAG_MAX : mag_ext[VAL_W-1:0];

    always_comb begin
        if (r_rec.invalid) begin
            value_next  = '0;
            status_next = ST_INVALID;
        end else begin
            value_next  = r_rec.negative ? (VAL_W'(0) - mag_clamped) : mag_clamped;
            status_next = (r_rec.overflow || too_wide) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_value  <= value_next;
            r_status <= status_next;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fixed_value = r_value;
    assign o_out.status      = r_status;
    assign o_stat.busy       = (r_state != BK_IDLE);

endmodule

[verif/dtfp_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfp_result_check
// Watches the character and result channels. Parses every accepted
// character string on its own, predicts the fixed-point value and status,
// and compares each accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module dtfp_result_check #(
    parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dtfp_in_if   i_in_ch,
    dtfp_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import dtfp_pkg::*;

    localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;
    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
    } t_parsed_number;

    t_parsed_number predicted_numbers[$];
    t_parsed_number oldest;
    t_parsed_number fresh;

    // Parser state of the string in progress
    logic                  first_char;
    logic                  minus_seen;
    logic                  in_frac;
    logic                  bad_char;
    logic                  int_ovf;
    logic [INT_ACC_W-1:0]  int_part;
    logic [FRAC_ACC_W-1:0] frac_part;
    logic [CNT_W-1:0]      frac_cnt;

    int fails   = 0;
    int checked = 0;

    task automatic clear_parser();
        first_char = 1'b1;
        minus_seen = 1'b0;
        in_frac    = 1'b0;
        bad_char   = 1'b0;
        int_ovf    = 1'b0;
        int_part   = '0;
        frac_part  = '0;
        frac_cnt   = '0;
    endtask

    task automatic take_char(input logic [7:0] ch);
        logic [63:0] digit;
        logic [63:0] next;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            digit = 64'(ch - CH_ZERO);
            if (in_frac) begin
                // drop digits past the kept precision
                if (frac_cnt < FRAC_DIGITS && frac_cnt < 9) begin
                    frac_part = FRAC_ACC_W'(64'(frac_part) * 64'd10 + digit);
                    frac_cnt  = frac_cnt + 1'b1;
                end
            end else begin
                next = 64'(int_part) * 64'd10 + digit;
                if (next > INT_LIMIT) begin
                    next    = INT_LIMIT;
                    int_ovf = 1'b1;
                end
                int_part = INT_ACC_W'(next);
            end
        end else if (ch == CH_MINUS) begin
            if (first_char) begin
                minus_seen = 1'b1;
            end else begin
                bad_char = 1'b1;
            end
        end else if (ch == CH_DOT) begin
            if (in_frac) begin
                bad_char = 1'b1;
            end else begin
                in_frac = 1'b1;
            end
        end else begin
            bad_char = 1'b1;
        end
        first_char = 1'b0;
    endtask

    task automatic close_string(output t_parsed_number num);
        logic [63:0] divisor;
        logic [63:0] frac_q;
        logic [63:0] mag;
        divisor = 64'd1;
        if (bad_char) begin
            num.value  = '0;
            num.status = ST_INVALID;
        end else begin
            for (int k = 0; k < frac_cnt && k < 9; k++) begin
                divisor = divisor * 64'd10;
            end
            frac_q     = (64'(frac_part) << FRAC_BITS) / divisor;
            mag        = (64'(int_part) << FRAC_BITS) + frac_q;
            num.status = int_ovf ? ST_SATURATED : ST_OK;
            if (mag > MAG_LIMIT) begin
                mag        = MAG_LIMIT;
                num.status = ST_SATURATED;
            end
            // truncate the magnitude first, then negate
            num.value = minus_seen ? VAL_W'(64'd0 - mag) : VAL_W'(mag);
        end
        clear_parser();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            predicted_numbers.delete();
        end else begin
            // retire the oldest prediction first
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (predicted_numbers.size() == 0) begin
                    $error("result with no string pending: fixed_value %0d status %0d",
                           i_out_ch.fixed_value, i_out_ch.status);
                    fails++;
                end else begin
                    oldest = predicted_numbers.pop_front();
                    if (i_out_ch.fixed_value !== oldest.value) begin
                        $error("fixed_value: expected %0d, actual %0d",
                               oldest.value, i_out_ch.fixed_value);
                        fails++;
                    end
                    if (i_out_ch.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest.status, i_out_ch.status);
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                take_char(i_in_ch.character);
                if (i_in_ch.last_char) begin
                    close_string(fresh);
                    predicted_numbers.insert(predicted_numbers.size(), fresh);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= predicted_numbers.size();
        o_checked    <= checked;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives character strings into the decimal text to fixed-point converter
// and gives the verdict. A short directed set covers the corner strings;
// random strings, mostly well formed, follow in three idling phases with
// a long result stall and full drains. Checking is done beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import dtfp_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    // last character to result with an idle back end
    localparam int LATENCY     = FRAC_BITS + 3;
    localparam int LONG_STALL  = 400;
    localparam int PHASE_CHARS = 430;
    localparam int CYCLE_LIMIT = 500000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtfp_in_if  in_ch();
    dtfp_out_if out_ch();

    int fail_count;
    int pending;
    int checked;

    // Idling odds in percent, per side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Bumped to ask the receiver for one long hold-off
    int stall_requests = 0;

    int cycle_count  = 0;
    int chars_sent   = 0;
    int strings_sent = 0;

    // Characters of the string about to be sent
    logic [7:0] text_buf[$];

    decimal_text_to_fixed_point #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    dtfp_result_check #(
        .FRAC_BITS(FRAC_BITS)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    // The hold-off is counted here so that the sender keeps offering items
    // while the block fills up behind the stalled result register.
    initial begin : result_sink
        int stall_left;
        int stalls_served;
        stall_left    = 0;
        stalls_served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one character and hold it until accepted. Valid is left high on
    // return, so a back-to-back item only updates the payload; a gap lowers
    // valid first, in the step of the previous acceptance.
    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.character <= ch;
        in_ch.last_char <= fin;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        chars_sent++;
    endtask

    // Send the buffered string, marking its final character.
    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
        strings_sent++;
    endtask

    // Add one character at the end of the string buffer.
    task automatic append_char(input logic [7:0] ch);
        text_buf.insert(text_buf.size(), ch);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_char(s[i]);
        end
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        push_text(s);
        send_buffer();
    endtask

    task automatic send_single(input logic [7:0] ch);
        text_buf.delete();
        append_char(ch);
        send_buffer();
    endtask

    task automatic push_digits(input int n);
        repeat (n) append_char(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // Digit run length: mostly short, sometimes up to the kept precision,
    // sometimes past it (integer saturation, dropped fraction digits).
    function automatic int digit_run(input int long_min, input int long_max);
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            return $urandom_range(3);
        end else if (r < 8) begin
            return $urandom_range(long_min - 1, 4);
        end
        return $urandom_range(long_max, long_min);
    endfunction

    // Build one random string: noise, a well-formed number, or a number
    // broken by one stray byte, minus or dot.
    task automatic make_random_string();
        int kind;
        int pos;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(4, 1)) append_char(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(2) == 0) begin
                append_char(CH_MINUS);
            end
            if ($urandom_range(9) == 0) begin
                // sit right at the saturation boundary
                push_text("214748364");
                push_digits(1);
            end else begin
                push_digits(digit_run(10, 12));
            end
            if ($urandom_range(3) != 0) begin
                append_char(CH_DOT);
                push_digits(digit_run(10, 11));
            end
            if (text_buf.size() == 0) begin
                push_digits(1);
            end
            if (kind < 27) begin
                pos = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(2))
                    0: begin
                        text_buf[pos] = 8'($urandom_range(255));
                    end
                    1: begin
                        text_buf.insert(pos, CH_MINUS);
                    end
                    default: begin
                        text_buf.insert(pos, CH_DOT);
                    end
                endcase
            end
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    // Wait for the next edge first so the count includes the string just closed.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit long_stall);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (long_stall) begin
            stall_requests++;
        end
        target = chars_sent + PHASE_CHARS;
        while (chars_sent < target) begin
            make_random_string();
            send_buffer();
            // an occasional full drain lands the pause on varied states
            if ($urandom_range(19) == 0) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.character <= '0;
        in_ch.last_char <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: strings with no digits, misplaced signs and dots,
        // byte extremes, integer saturation and dropped fraction digits.
        send_text("-");
        send_text(".");
        send_text("-0");
        send_text(".-");
        send_text("--");
        send_text("..");
        send_single(8'hFF);
        send_single(8'h00);
        send_text("9");
        send_text("-2147483648");
        send_text(".1234567899");
        drain_results();

        // Random: slow receiver, then slow sender, then full rate with a
        // long result stall so the input side backs up.
        run_phase(33, 87, 1'b0);
        run_phase(87, 33, 1'b0);
        run_phase(0, 0, 1'b1);

        // Let anything still in the back end show up before the verdict.
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("sent %0d strings in %0d characters over three idling phases",
                 strings_sent, chars_sent);
        $display("compared %0d results, %0d mismatches, one long result stall",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
